// ===== hdl/gca_pkg.sv =====
package gca_pkg;

  localparam int unsigned WordWidth  = 64;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned RWidth     = 5;
  localparam int unsigned SWidth     = 7;
  localparam int unsigned TWidth     = 5;
  localparam int unsigned RDepth     = 7;
  localparam int unsigned SDepth     = 7;
  localparam int unsigned TDepth     = 5;
  localparam int unsigned GroupWidth = 3;
  localparam int unsigned PosWidth   = 2;
  localparam int unsigned StepWidth  = 6;

  localparam logic [4:0] Mod31  = 5'd31;
  localparam logic [6:0] Mod127 = 7'd127;

  // configuration register indexes
  typedef enum logic {
    CFG_CRYPTO = 1'b0,
    CFG_SEED   = 1'b1
  } cfg_index_t;

  // controller to datapath
  typedef struct packed {
    logic                  clear;    // start of item: zero registers, take challenge
    logic                  absorb;   // clock registers with an injected byte
    logic                  gen;      // clock registers with no injection
    logic                  load_out; // move finished byte pair to output register
    logic [GroupWidth-1:0] grp;      // absorb group, 0..7
    logic [PosWidth-1:0]   pos;      // position in group, 0..2
    logic [StepWidth-1:0]  step;     // output step, 0..63
  } gca_cmd_t;

  // sum of two 5-bit values, folded into 1..31 when above 31
  function automatic logic [4:0] fold31(input logic [5:0] sum);
    logic [5:0] diff;
    diff = sum - {1'b0, Mod31};
    return (sum > {1'b0, Mod31}) ? diff[4:0] : sum[4:0];
  endfunction

  // sum of two 7-bit values, folded into 1..127 when above 127
  function automatic logic [6:0] fold127(input logic [7:0] sum);
    logic [7:0] diff;
    diff = sum - {1'b0, Mod127};
    return (sum > {1'b0, Mod127}) ? diff[6:0] : sum[6:0];
  endfunction

endpackage

// ===== hdl/gpa_cipher_authenticator.sv =====
// Channel   Direction  Handshake             Payload
// in        to block   in_valid / in_ready   host_challenge
// out       from block out_valid / out_ready byte_index, session_byte, response_byte, last_pair
// cfg       to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A challenge is taken, then run through 24 absorb steps and 64 output steps,
// one register clock per cycle through the shared R/S/T shift unit while the
// output steps are not stalled. Eight byte pairs come out; the next challenge
// is taken once the last step is done, even with the final pair still held.
// A pair still unread when the next one finishes stalls the output steps.
// rst is synchronous; it clears control state and both configuration words.
module gpa_cipher_authenticator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] host_challenge,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_index,
  output logic [7:0]  session_byte,
  output logic [7:0]  response_byte,
  output logic        last_pair,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  gca_pkg::gca_cmd_t cmd;

  assign cfg_ready = 1'b1;

  gca_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  gca_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .host_challenge (host_challenge),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .byte_index     (byte_index),
    .session_byte   (session_byte),
    .response_byte  (response_byte),
    .last_pair      (last_pair)
  );

endmodule

// ===== hdl/gca_datapath.sv =====
module gca_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  gca_pkg::gca_cmd_t          cmd,
  input  logic [gca_pkg::WordWidth-1:0] host_challenge,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [gca_pkg::WordWidth-1:0] cfg_data,
  output logic [2:0]                 byte_index,
  output logic [7:0]                 session_byte,
  output logic [7:0]                 response_byte,
  output logic                       last_pair
);

  logic [gca_pkg::WordWidth-1:0] crypto_value;
  logic [gca_pkg::WordWidth-1:0] secret_seed;
  logic [gca_pkg::WordWidth-1:0] challenge;

  logic [gca_pkg::RDepth-1:0][gca_pkg::RWidth-1:0] reg_r, reg_r_next;
  logic [gca_pkg::SDepth-1:0][gca_pkg::SWidth-1:0] reg_s, reg_s_next;
  logic [gca_pkg::TDepth-1:0][gca_pkg::TWidth-1:0] reg_t, reg_t_next;

  logic [7:0] sess_acc;
  logic [3:0] resp_hi;

  logic [7:0]                    key_word_byte;
  logic [7:0]                    chal_byte;
  logic [7:0]                    in_byte;
  logic [gca_pkg::WordWidth-1:0] key_word;
  logic [2:0]                    key_sel;
  logic [4:0]                    inj_r, inj_t;
  logic [6:0]                    inj_s;
  logic [4:0]                    rot_r;
  logic [6:0]                    rot_s;
  logic [3:0]                    mix_a, mix_c, mix_x;
  logic [3:0]                    nibble;

  // byte to absorb: two key bytes then one challenge byte per group
  always_comb begin
    key_word      = cmd.grp[2] ? secret_seed : crypto_value;
    key_sel       = {cmd.grp[1:0], cmd.pos[0]};
    key_word_byte = key_word[{key_sel, 3'b000} +: 8];
    chal_byte     = challenge[{cmd.grp, 3'b000} +: 8];
    in_byte       = (cmd.pos == 2'd2) ? chal_byte : key_word_byte;
  end

  always_comb begin
    if (cmd.absorb) begin
      inj_r = in_byte[4:0];
      inj_s = {in_byte[3:0], in_byte[7:5]};
      inj_t = in_byte[7:3];
    end else begin
      inj_r = '0;
      inj_s = '0;
      inj_t = '0;
    end
  end

  always_comb begin
    rot_r = {reg_r[6][3:0], reg_r[6][4]};
    reg_r_next[6] = reg_r[5];
    reg_r_next[5] = reg_r[4];
    reg_r_next[4] = reg_r[3];
    reg_r_next[3] = reg_r[2] ^ inj_r;
    reg_r_next[2] = reg_r[1];
    reg_r_next[1] = reg_r[0];
    reg_r_next[0] = gca_pkg::fold31({1'b0, reg_r[3]} + {1'b0, rot_r});

    rot_s = {reg_s[6][5:0], reg_s[6][6]};
    reg_s_next[6] = reg_s[5];
    reg_s_next[5] = reg_s[4] ^ inj_s;
    reg_s_next[4] = reg_s[3];
    reg_s_next[3] = reg_s[2];
    reg_s_next[2] = reg_s[1];
    reg_s_next[1] = reg_s[0];
    reg_s_next[0] = gca_pkg::fold127({1'b0, reg_s[5]} + {1'b0, rot_s});

    reg_t_next[4] = reg_t[3];
    reg_t_next[3] = reg_t[2];
    reg_t_next[2] = reg_t[1] ^ inj_t;
    reg_t_next[1] = reg_t[0];
    reg_t_next[0] = gca_pkg::fold31({1'b0, reg_t[2]} + {1'b0, reg_t[4]});

    // keystream nibble from the freshly clocked registers
    mix_a  = reg_r_next[0][3:0] ^ reg_r_next[4][3:0];
    mix_c  = reg_t_next[0][3:0] ^ reg_t_next[3][3:0];
    mix_x  = reg_s_next[0][3:0];
    nibble = (mix_a & ~mix_x) | (mix_x & mix_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crypto_value <= '0;
      secret_seed  <= '0;
    end else if (cfg_we) begin
      case (gca_pkg::cfg_index_t'(cfg_index))
        gca_pkg::CFG_CRYPTO: crypto_value <= cfg_data;
        gca_pkg::CFG_SEED:   secret_seed  <= cfg_data;
        default:             crypto_value <= crypto_value;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      reg_r     <= '0;
      reg_s     <= '0;
      reg_t     <= '0;
      challenge <= host_challenge;
    end else if (cmd.absorb || cmd.gen) begin
      reg_r <= reg_r_next;
      reg_s <= reg_s_next;
      reg_t <= reg_t_next;
    end
  end

  // only the second step of each pair yields a nibble
  always_ff @(posedge clk) begin
    if (cmd.gen && cmd.step[0]) begin
      case (cmd.step[2:1])
        2'd0:    sess_acc[7:4] <= nibble;
        2'd1:    sess_acc[3:0] <= nibble;
        2'd2:    resp_hi       <= nibble;
        default: resp_hi       <= resp_hi;
      endcase
    end
    if (cmd.load_out) begin
      byte_index    <= cmd.step[5:3];
      session_byte  <= sess_acc;
      response_byte <= {resp_hi, nibble};
      last_pair     <= &cmd.step[5:3];
    end
  end

endmodule

// ===== hdl/gca_controller.sv =====
module gca_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gca_pkg::gca_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    ABSORB,
    GEN
  } state_t;

  state_t                            state;
  logic [gca_pkg::GroupWidth-1:0]    grp;
  logic [gca_pkg::PosWidth-1:0]      pos;
  logic [gca_pkg::StepWidth-1:0]     step;
  logic                              pair_end;
  logic                              gen_go;

  assign in_ready = (state == IDLE);
  assign pair_end = (&step[2:0]);
  // hold the step that finishes a pair while the last pair is still unread
  assign gen_go   = (state == GEN) && !(pair_end && out_valid && !out_ready);

  always_comb begin
    cmd          = '0;
    cmd.clear    = in_valid && in_ready;
    cmd.absorb   = (state == ABSORB);
    cmd.gen      = gen_go;
    cmd.load_out = gen_go && pair_end;
    cmd.grp      = grp;
    cmd.pos      = pos;
    cmd.step     = step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      grp       <= '0;
      pos       <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= ABSORB;
            grp   <= '0;
            pos   <= '0;
          end
        end
        ABSORB: begin
          if (pos == 2'd2) begin
            pos <= '0;
            grp <= grp + 3'd1;
            if (&grp) begin
              state <= GEN;
              step  <= '0;
            end
          end else begin
            pos <= pos + 2'd1;
          end
        end
        GEN: begin
          if (gen_go) begin
            step <= step + 6'd1;
            if (&step) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // a finished pair never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output pair overwritten");

  // every item starts absorbing at the first group
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ABSORB && grp == '0 && pos == '0))
    else $error("absorb did not start cleanly");

  // the last output step returns to idle
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (gen_go && (&step)) |=> (state == IDLE && out_valid))
    else $error("item did not finish after last pair");

  a_no_absorb_in_gen: assert property (@(posedge clk) disable iff (rst)
    !(cmd.absorb && cmd.gen))
    else $error("absorb and output step together");

endmodule
